// ===== sv/fbe_pkg.sv =====
// Shared operation codes and controller/datapath link types for the framebuffer engine.
package fbe_pkg;

  typedef logic [2:0] func_t;

  localparam func_t OP_SET_PIXEL   = 3'd0;
  localparam func_t OP_CLEAR_PIXEL = 3'd1;
  localparam func_t OP_WRITE_BYTE  = 3'd2;
  localparam func_t OP_INVERT_BYTE = 3'd3;
  localparam func_t OP_CLEAR_ALL   = 3'd4;
  localparam func_t OP_READ_BYTE   = 3'd5;

  typedef struct packed {
    logic load;        // latch the accepted item
    logic write_item;  // write the modified byte back
    logic sweep;       // zero one byte at the sweep index and advance
    logic out_load;    // move the read byte into the result register
  } fbe_cmd_t;

  typedef struct packed {
    logic item_ok;     // incoming item addresses a byte inside the store
    logic out_busy;    // result register holds an item not taken this cycle
    logic sweep_last;  // sweep index is at the last byte
  } fbe_sts_t;

endpackage

// ===== sv/fbe_op_if.sv =====
// Operation channel: valid/ready handshake carrying one framebuffer operation.
interface fbe_op_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] x_pos;
  logic [5:0] y_pos;
  logic [2:0] page;
  logic [7:0] data;

  modport source (output valid, func, x_pos, y_pos, page, data, input ready);
  modport sink   (input valid, func, x_pos, y_pos, page, data, output ready);
endinterface

// ===== sv/fbe_result_if.sv =====
// Result channel: valid/ready handshake carrying one read byte.
interface fbe_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== sv/fbe_ctrl.sv =====
// Controller state machine: sequences read-modify-write, reads and store sweeps.
module fbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  fbe_pkg::func_t   in_func,
  output logic             in_ready,
  input  fbe_pkg::fbe_sts_t sts,
  output fbe_pkg::fbe_cmd_t cmd
);

  localparam logic [2:0] ST_SWEEP  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_read;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_read <= (in_func == fbe_pkg::OP_READ_BYTE);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (in_func) inside
            fbe_pkg::OP_SET_PIXEL, fbe_pkg::OP_CLEAR_PIXEL,
            fbe_pkg::OP_WRITE_BYTE, fbe_pkg::OP_INVERT_BYTE: begin
              // out-of-range modifies are dropped here
              if (sts.item_ok) begin
                state_next = ST_READ;
              end
            end
            fbe_pkg::OP_READ_BYTE: state_next = ST_READ;
            fbe_pkg::OP_CLEAR_ALL: state_next = ST_SWEEP;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        state_next = is_read ? ST_LOAD : ST_MODIFY;
      end
      ST_MODIFY: begin
        cmd.write_item = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_LOAD: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
  end

endmodule

// ===== sv/fbe_dp.sv =====
// Datapath: frame store memory, item registers, byte modify logic and result register.
module fbe_dp #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  fbe_pkg::func_t    in_func,
  input  logic [6:0]        in_x_pos,
  input  logic [5:0]        in_y_pos,
  input  logic [2:0]        in_page,
  input  logic [7:0]        in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  input  fbe_pkg::fbe_cmd_t cmd,
  output fbe_pkg::fbe_sts_t sts
);

  localparam int PAGES  = (HEIGHT + 7) / 8;
  localparam int DEPTH  = WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] sweep_idx;
  logic [ADDR_W-1:0] item_addr;
  logic [2:0]        item_bit;
  logic [7:0]        item_data;
  fbe_pkg::func_t    item_func;
  logic              item_ok;

  logic              is_pixel;
  logic              pix_ok;
  logic              byte_ok;
  logic [2:0]        page_sel;
  logic [ADDR_W-1:0] addr_next;
  logic [7:0]        bit_mask;
  logic [7:0]        new_byte;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  assign is_pixel = (in_func == fbe_pkg::OP_SET_PIXEL) || (in_func == fbe_pkg::OP_CLEAR_PIXEL);
  assign pix_ok   = (int'(in_y_pos) < HEIGHT) && (int'(in_x_pos) < WIDTH);
  assign byte_ok  = (int'(in_page) < PAGES) && (int'(in_x_pos) < WIDTH);
  assign page_sel = is_pixel ? in_y_pos[5:3] : in_page;
  assign addr_next = ADDR_W'(int'(page_sel) * WIDTH + int'(in_x_pos));

  assign sts.item_ok    = is_pixel ? pix_ok : byte_ok;
  assign sts.out_busy   = out_valid && !out_ready;
  assign sts.sweep_last = (sweep_idx == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_func <= in_func;
      item_addr <= addr_next;
      item_bit  <= in_y_pos[2:0];
      item_data <= in_data;
      item_ok   <= sts.item_ok;
    end
  end

  assign bit_mask = 8'(1) << item_bit;

  always_comb begin
    case (item_func)
      fbe_pkg::OP_SET_PIXEL:   new_byte = rd_data | bit_mask;
      fbe_pkg::OP_CLEAR_PIXEL: new_byte = rd_data & ~bit_mask;
      fbe_pkg::OP_WRITE_BYTE:  new_byte = item_data;
      fbe_pkg::OP_INVERT_BYTE: new_byte = ~rd_data;
      default:                 new_byte = rd_data;
    endcase
  end

  assign mem_we    = cmd.sweep || cmd.write_item;
  assign mem_addr  = cmd.sweep ? sweep_idx : item_addr;
  assign mem_wdata = cmd.sweep ? 8'h00 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[item_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep) begin
      sweep_idx <= sts.sweep_last ? '0 : sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data <= item_ok ? rd_data : 8'h00;
    end
  end

endmodule

// ===== sv/page_framebuffer_engine_top.sv =====
// Monochrome page-organized framebuffer of WIDTH by HEIGHT pixels, one operation per item.
// Set pixel, clear pixel, write byte and invert byte each step through accept, read the
// byte and write it back through the frame store; read byte steps through accept, read
// the byte and load it into the result channel's output register, which holds one result,
// waiting while that register is still full. Unused codes and out-of-range pixel or byte
// modifies are dropped at acceptance. Clear all sweeps the store one byte per cycle, and
// the same sweep runs after reset, so op.ready stays low after rst drops until it ends.
module page_framebuffer_engine_top #(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input logic         clk,
  input logic         rst,
  fbe_op_if.sink      op,
  fbe_result_if.source result
);

  fbe_pkg::fbe_cmd_t cmd;
  fbe_pkg::fbe_sts_t sts;

  fbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (op.valid),
    .in_func  (op.func),
    .in_ready (op.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbe_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_func       (op.func),
    .in_x_pos      (op.x_pos),
    .in_y_pos      (op.y_pos),
    .in_page       (op.page),
    .in_data       (op.data),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .out_read_data (result.read_data),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== sv/fbe_chk.sv =====
// Port-level checker for the framebuffer engine, bound to the top level.
module fbe_chk (
  input logic       clk,
  input logic       rst,
  input logic       op_valid,
  input logic       op_ready,
  input logic [2:0] op_func,
  input logic       res_valid,
  input logic       res_ready
);

  a_reset_blocks: assert property (@(posedge clk) rst |=> !op_ready && !res_valid)
    else $error("item accepted or result shown right after reset");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready && op_func == fbe_pkg::OP_READ_BYTE) |=> !op_ready)
    else $error("new item accepted while a read is in flight");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready && op_func == fbe_pkg::OP_CLEAR_ALL) |=> !op_ready)
    else $error("new item accepted during clear sweep");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before it was taken");

endmodule

bind page_framebuffer_engine_top fbe_chk u_fbe_chk (
  .clk       (clk),
  .rst       (rst),
  .op_valid  (op.valid),
  .op_ready  (op.ready),
  .op_func   (op.func),
  .res_valid (result.valid),
  .res_ready (result.ready)
);

// ===== tb/page_framebuffer_engine_top_tb.sv =====
// Self-checking testbench for page_framebuffer_engine_top: directed table then random operations.
module page_framebuffer_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PANEL_W      = 128;
  localparam int PANEL_PAGES  = 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 1100;

  localparam fbe_pkg::func_t OP_UNUSED_6 = 3'd6;
  localparam fbe_pkg::func_t OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    fbe_pkg::func_t func;
    logic [6:0]     x_pos;
    logic [5:0]     y_pos;
    logic [2:0]     page;
    logic [7:0]     data;
    logic           has_known;
    logic [7:0]     known_byte;
  } op_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam op_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{fbe_pkg::OP_READ_BYTE,   7'd0,   6'd0,  3'd0, 8'h00, 1'b1, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd127, 6'd63, 3'd7, 8'hFF, 1'b1, 8'h00},
    '{fbe_pkg::OP_WRITE_BYTE,  7'd127, 6'd0,  3'd7, 8'hFF, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd127, 6'd0,  3'd7, 8'h00, 1'b1, 8'hFF},
    '{fbe_pkg::OP_SET_PIXEL,   7'd0,   6'd0,  3'd7, 8'hFF, 1'b0, 8'h00},
    '{fbe_pkg::OP_SET_PIXEL,   7'd0,   6'd7,  3'd0, 8'h00, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd0,   6'd63, 3'd0, 8'hFF, 1'b1, 8'h81},
    '{fbe_pkg::OP_CLEAR_PIXEL, 7'd0,   6'd0,  3'd7, 8'hFF, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd0,   6'd0,  3'd0, 8'h00, 1'b1, 8'h80},
    '{fbe_pkg::OP_CLEAR_PIXEL, 7'd127, 6'd63, 3'd0, 8'h00, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd127, 6'd0,  3'd7, 8'h00, 1'b1, 8'h7F},
    '{fbe_pkg::OP_INVERT_BYTE, 7'd127, 6'd0,  3'd7, 8'h00, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd127, 6'd0,  3'd7, 8'h00, 1'b1, 8'h80},
    '{fbe_pkg::OP_WRITE_BYTE,  7'd5,   6'd0,  3'd3, 8'hA5, 1'b0, 8'h00},
    '{fbe_pkg::OP_INVERT_BYTE, 7'd5,   6'd0,  3'd3, 8'hFF, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd5,   6'd0,  3'd3, 8'h00, 1'b1, 8'h5A},
    '{OP_UNUSED_6,             7'd0,   6'd0,  3'd0, 8'hFF, 1'b0, 8'h00},
    '{OP_UNUSED_7,             7'd127, 6'd63, 3'd7, 8'h00, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd0,   6'd0,  3'd0, 8'h00, 1'b1, 8'h80},
    '{fbe_pkg::OP_CLEAR_ALL,   7'd127, 6'd63, 3'd7, 8'hFF, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd127, 6'd0,  3'd7, 8'h00, 1'b1, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd5,   6'd0,  3'd3, 8'h00, 1'b1, 8'h00},
    '{fbe_pkg::OP_SET_PIXEL,   7'd64,  6'd35, 3'd0, 8'h00, 1'b0, 8'h00},
    '{fbe_pkg::OP_READ_BYTE,   7'd64,  6'd0,  3'd4, 8'h00, 1'b1, 8'h08},
    '{fbe_pkg::OP_READ_BYTE,   7'd0,   6'd0,  3'd0, 8'h00, 1'b1, 8'h00}
  };

  logic clk;
  logic rst;

  fbe_op_if     op ();
  fbe_result_if result ();

  page_framebuffer_engine_top #(
    .WIDTH (PANEL_W),
    .HEIGHT(PANEL_PAGES * 8)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .result(result)
  );

  logic [7:0] shadow_fb [PANEL_W * PANEL_PAGES];
  logic [7:0] read_q [$];
  logic [7:0] exp_byte;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 82;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    op.valid = 1'b0;
    op.func = fbe_pkg::OP_SET_PIXEL;
    op.x_pos = '0;
    op.y_pos = '0;
    op.page = '0;
    op.data = '0;
    result.ready = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
  end

  always #10 clk = ~clk;

  // Update the shadow framebuffer; return 1 when the operation yields a read byte.
  function automatic bit apply_op(input fbe_pkg::func_t f, input logic [6:0] x,
                                  input logic [5:0] y, input logic [2:0] pg,
                                  input logic [7:0] d, output logic [7:0] rd);
    logic [9:0] idx;
    rd = 8'h00;
    case (f)
      fbe_pkg::OP_SET_PIXEL: begin
        idx = {y[5:3], x};
        shadow_fb[idx][y[2:0]] = 1'b1;
      end
      fbe_pkg::OP_CLEAR_PIXEL: begin
        idx = {y[5:3], x};
        shadow_fb[idx][y[2:0]] = 1'b0;
      end
      fbe_pkg::OP_WRITE_BYTE: begin
        idx = {pg, x};
        shadow_fb[idx] = d;
      end
      fbe_pkg::OP_INVERT_BYTE: begin
        idx = {pg, x};
        shadow_fb[idx] = ~shadow_fb[idx];
      end
      fbe_pkg::OP_CLEAR_ALL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      end
      fbe_pkg::OP_READ_BYTE: begin
        idx = {pg, x};
        rd = shadow_fb[idx];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Present one item, hold it until accepted, then book the expected read byte.
  task automatic issue_op(input fbe_pkg::func_t f, input logic [6:0] x, input logic [5:0] y,
                          input logic [2:0] pg, input logic [7:0] d,
                          input bit has_known, input logic [7:0] known_byte);
    logic [7:0] rd;
    bit         gives;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      op.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    op.valid <= 1'b1;
    op.func  <= f;
    op.x_pos <= x;
    op.y_pos <= y;
    op.page  <= pg;
    op.data  <= d;
    do @(posedge clk); while (!op.ready);
    gives = apply_op(f, x, y, pg, d, rd);
    if (gives) read_q.push_back(has_known ? known_byte : rd);
  endtask

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (read_q.size() == 0) begin
        $error("read_data: no read pending, actual %02h", result.read_data);
        fail_count++;
      end else begin
        exp_byte = read_q.pop_front();
        if (result.read_data !== exp_byte) begin
          $error("read_data: expected %02h, actual %02h", exp_byte, result.read_data);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_framebuffer_engine_top test failed");
      $finish;
    end
  end

  initial begin
    fbe_pkg::func_t f;
    logic [6:0]     x;
    logic [5:0]     y;
    logic [2:0]     pg;
    logic [7:0]     d;
    int             pick;
    int             n;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      issue_op(DIRECTED[i].func, DIRECTED[i].x_pos, DIRECTED[i].y_pos, DIRECTED[i].page,
               DIRECTED[i].data, DIRECTED[i].has_known, DIRECTED[i].known_byte);
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n < RANDOM_ITEMS / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 82;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick = $urandom_range(99);
      if (pick < 3)       f = $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
      else if (pick < 5)  f = fbe_pkg::OP_CLEAR_ALL;
      else if (pick < 20) f = fbe_pkg::OP_WRITE_BYTE;
      else if (pick < 32) f = fbe_pkg::OP_INVERT_BYTE;
      else if (pick < 50) f = fbe_pkg::OP_SET_PIXEL;
      else if (pick < 65) f = fbe_pkg::OP_CLEAR_PIXEL;
      else                f = fbe_pkg::OP_READ_BYTE;

      // Keep most accesses on a few columns at each edge so reads hit modified bytes.
      if ($urandom_range(3) != 0)
        x = $urandom_range(1) ? 7'($urandom_range(3)) : 7'(124 + $urandom_range(3));
      else
        x = 7'($urandom_range(127));
      pg = 3'($urandom_range(7));
      y  = $urandom_range(3) != 0 ? {pg, 3'($urandom_range(7))} : 6'($urandom_range(63));
      d  = 8'($urandom_range(255));

      issue_op(f, x, y, pg, d, 1'b0, 8'h00);
      if (f != OP_UNUSED_6 && f != OP_UNUSED_7) n++;
    end
    op.valid <= 1'b0;

    while (read_q.size() != 0) @(posedge clk);
    // Leave room for a trailing clear-all sweep and any stray result.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("page_framebuffer_engine_top test passed");
    end else begin
      $display("page_framebuffer_engine_top test failed");
    end
    $finish;
  end

endmodule
